// File: rtl/bsap_pkg.sv
// ----------------------------------------------------------------------------
// bsap_pkg
// Shared types and constants of the bulk string array parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsap_pkg;

    localparam int ARGS_CEILING   = 32;
    localparam int MAX_BULK_BYTES = 16384;
    localparam int MAX_LINE_CHARS = 31;

    localparam int NUM_W   = 15;
    localparam int LINE_W  = 6;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 5;
    localparam int LEN_W   = 14;
    localparam int BYTE_W  = 8;

    localparam int ARG_CAP     = (ARGS_CEILING < 32) ? ARGS_CEILING : 32;
    localparam int LEN_MAX_INT = ((MAX_BULK_BYTES - 1) < 16383) ? (MAX_BULK_BYTES - 1) : 16383;

    localparam logic [NUM_W-1:0]  C_NUM_MAX   = 15'd32767;
    localparam logic [NUM_W-1:0]  C_LEN_MAX   = NUM_W'(LEN_MAX_INT);
    localparam logic [CNT_W-1:0]  C_ARG_CAP   = CNT_W'(ARG_CAP);
    localparam logic [LINE_W-1:0] C_LINE_MAX  = LINE_W'(MAX_LINE_CHARS);
    localparam logic [CNT_W-1:0]  C_ARG_RESET = 6'd32;

    localparam logic [BYTE_W-1:0] C_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] C_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] C_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] C_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] C_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] C_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] C_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] C_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] C_FF     = 8'h0C;
    localparam logic [BYTE_W-1:0] C_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] C_NINE   = 8'h39;

    typedef enum logic [3:0] {
        PH_STAR     = 4'd0,
        PH_COUNT    = 4'd1,
        PH_COUNT_LF = 4'd2,
        PH_DOLLAR   = 4'd3,
        PH_LEN      = 4'd4,
        PH_LEN_LF   = 4'd5,
        PH_PAYLOAD  = 4'd6,
        PH_TRAIL1   = 4'd7,
        PH_TRAIL2   = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        NS_SKIP   = 2'd0,
        NS_DIGITS = 2'd1,
        NS_DONE   = 2'd2
    } t_nstage;

    typedef enum logic [1:0] {
        K_PAYLOAD = 2'd0,
        K_ARG_END = 2'd1,
        K_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        E_NO_STAR    = 3'd0,
        E_LINE_LONG  = 3'd1,
        E_BAD_COUNT  = 3'd2,
        E_NO_DOLLAR  = 3'd3,
        E_NEG_LEN    = 3'd4,
        E_LEN_LARGE  = 3'd5,
        E_CR_NO_LF   = 3'd6
    } t_err;

    typedef struct packed {
        t_nstage          stage;
        logic             neg;
        logic [NUM_W-1:0] value;
    } t_num;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  cnt;
        logic [LEN_W-1:0]  len;
        logic              last;
        t_err              err;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/bsap_num.sv
// ----------------------------------------------------------------------------
// bsap_num
// Decimal number reader: combinational step over one character of a number line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsap_num
    import bsap_pkg::*;
(
    input  wire logic [BYTE_W-1:0] i_char,
    input  wire t_num              i_num,
    output t_num                   o_num
);

    logic              digit;
    logic              space;
    logic [NUM_W+3:0]  acc;
    logic [NUM_W-1:0]  acc_sat;

    always_comb begin
        digit   = (i_char >= C_ZERO) && (i_char <= C_NINE);
        space   = (i_char == C_SPACE) || ((i_char >= C_TAB) && (i_char <= C_FF));
        acc     = (NUM_W+4)'(i_num.value) * (NUM_W+4)'(10) + (NUM_W+4)'(i_char[3:0]);
        acc_sat = (acc > (NUM_W+4)'(C_NUM_MAX)) ? C_NUM_MAX : acc[NUM_W-1:0];
        o_num   = i_num;
        case (i_num.stage)
            NS_SKIP: begin
                if (space) begin
                    o_num = i_num;
                end else if (i_char == C_PLUS || i_char == C_MINUS) begin
                    o_num.neg   = (i_char == C_MINUS);
                    o_num.stage = NS_DIGITS;
                end else if (digit) begin
                    o_num.stage = NS_DIGITS;
                    o_num.value = acc_sat;
                end else begin
                    o_num.stage = NS_DONE;
                end
            end
            NS_DIGITS: begin
                if (digit) begin
                    o_num.value = acc_sat;
                end else begin
                    o_num.stage = NS_DONE;
                end
            end
            default: begin
                o_num = i_num;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/bsap_fsm.sv
// ----------------------------------------------------------------------------
// bsap_fsm
// Request parser state and per-byte step logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsap_fsm
    import bsap_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [CNT_W-1:0]  i_arg_limit,
    output logic                   o_res_valid,
    output t_result                o_res
);

    t_phase            r_phase,        n_phase;
    t_num              r_num,          n_num;
    logic [LINE_W-1:0] r_line_chars,   n_line_chars;
    logic [CNT_W-1:0]  r_request_args, n_request_args;
    logic [IDX_W-1:0]  r_current_arg,  n_current_arg;
    logic [LEN_W-1:0]  r_payload_left, n_payload_left;
    logic [LEN_W-1:0]  r_current_len,  n_current_len;

    t_num              num_fed;
    logic              err;
    t_err              err_code;
    logic [CNT_W-1:0]  limit;
    logic              last;

    bsap_num u_num (
        .i_char (i_byte),
        .i_num  (r_num),
        .o_num  (num_fed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_STAR;
            r_num          <= '0;
            r_line_chars   <= '0;
            r_request_args <= '0;
            r_current_arg  <= '0;
            r_payload_left <= '0;
            r_current_len  <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_num          <= n_num;
            r_line_chars   <= n_line_chars;
            r_request_args <= n_request_args;
            r_current_arg  <= n_current_arg;
            r_payload_left <= n_payload_left;
            r_current_len  <= n_current_len;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_num          = r_num;
        n_line_chars   = r_line_chars;
        n_request_args = r_request_args;
        n_current_arg  = r_current_arg;
        n_payload_left = r_payload_left;
        n_current_len  = r_current_len;
        err            = 1'b0;
        err_code       = E_NO_STAR;
        o_res_valid    = 1'b0;
        o_res          = '0;
        limit          = (i_arg_limit > C_ARG_CAP) ? C_ARG_CAP : i_arg_limit;
        last           = ({1'b0, r_current_arg} + CNT_W'(1)) >= r_request_args;

        unique case (r_phase)
            PH_STAR: begin
                if (i_byte != C_STAR) begin
                    err = 1'b1;
                end else begin
                    n_num        = '0;
                    n_line_chars = '0;
                    n_phase      = PH_COUNT;
                end
            end
            PH_COUNT, PH_LEN: begin
                if (i_byte == C_CR) begin
                    n_phase = (r_phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
                end else if (r_line_chars >= C_LINE_MAX) begin
                    err      = 1'b1;
                    err_code = E_LINE_LONG;
                end else begin
                    n_line_chars = r_line_chars + LINE_W'(1);
                    n_num        = num_fed;
                end
            end
            PH_COUNT_LF: begin
                if (i_byte != C_LF) begin
                    err      = 1'b1;
                    err_code = E_CR_NO_LF;
                end else if (r_num.neg || r_num.value == '0
                             || r_num.value > NUM_W'(limit)) begin
                    err      = 1'b1;
                    err_code = E_BAD_COUNT;
                end else begin
                    n_request_args = r_num.value[CNT_W-1:0];
                    n_current_arg  = '0;
                    n_phase        = PH_DOLLAR;
                end
            end
            PH_DOLLAR: begin
                if (i_byte != C_DOLLAR) begin
                    err      = 1'b1;
                    err_code = E_NO_DOLLAR;
                end else begin
                    n_num        = '0;
                    n_line_chars = '0;
                    n_phase      = PH_LEN;
                end
            end
            PH_LEN_LF: begin
                if (i_byte != C_LF) begin
                    err      = 1'b1;
                    err_code = E_CR_NO_LF;
                end else if (r_num.neg && r_num.value != '0) begin
                    err      = 1'b1;
                    err_code = E_NEG_LEN;
                end else if (r_num.value > C_LEN_MAX) begin
                    err      = 1'b1;
                    err_code = E_LEN_LARGE;
                end else begin
                    n_current_len  = r_num.value[LEN_W-1:0];
                    n_payload_left = r_num.value[LEN_W-1:0];
                    n_phase        = (r_num.value == '0) ? PH_TRAIL1 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                o_res_valid    = 1'b1;
                o_res.kind     = K_PAYLOAD;
                o_res.data     = i_byte;
                o_res.idx      = r_current_arg;
                o_res.cnt      = r_request_args;
                o_res.len      = r_current_len;
                n_payload_left = r_payload_left - LEN_W'(1);
                if (n_payload_left == '0) begin
                    n_phase = PH_TRAIL1;
                end
            end
            PH_TRAIL1: begin
                n_phase = PH_TRAIL2;
            end
            PH_TRAIL2: begin
                o_res_valid = 1'b1;
                o_res.kind  = K_ARG_END;
                o_res.idx   = r_current_arg;
                o_res.cnt   = r_request_args;
                o_res.len   = r_current_len;
                o_res.last  = last;
                if (last) begin
                    n_phase        = PH_STAR;
                    n_num          = '0;
                    n_line_chars   = '0;
                    n_request_args = '0;
                    n_current_arg  = '0;
                    n_payload_left = '0;
                    n_current_len  = '0;
                end else begin
                    n_current_arg = r_current_arg + IDX_W'(1);
                    n_phase       = PH_DOLLAR;
                end
            end
            default: begin
                n_phase        = PH_STAR;
                n_num          = '0;
                n_line_chars   = '0;
                n_request_args = '0;
                n_current_arg  = '0;
                n_payload_left = '0;
                n_current_len  = '0;
            end
        endcase

        // restart on any error
        if (err) begin
            n_phase        = PH_STAR;
            n_num          = '0;
            n_line_chars   = '0;
            n_request_args = '0;
            n_current_arg  = '0;
            n_payload_left = '0;
            n_current_len  = '0;
            o_res_valid    = 1'b1;
            o_res          = '0;
            o_res.kind     = K_ERROR;
            o_res.err      = err_code;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bulk_string_array_parser_unit.sv
// ----------------------------------------------------------------------------
// bulk_string_array_parser_unit
// Byte-serial parser of bulk string array requests.
//
// Input channel i_valid/o_ready carries one request byte per word. Output
// channel o_valid/i_ready carries one result word: a payload byte, an
// argument end (o_last_argument marks the final argument of a request) or a
// parse error with o_error_code. Bytes that produce no result (markers,
// number lines, the first trailer byte) are consumed silently.
// Configuration channel i_cfg_valid/o_cfg_ready writes arg_limit; it is
// always ready and must be written only while the parser is idle.
// Path: an accepted byte waits in the input register until it is parsed; any
// result is loaded into the output register, whose valid bit drives o_valid.
// Throughput: one byte per cycle while the output is not stalled, set by the
// combinational parse step between input register and output register.
// Stall: while the output register holds an untaken word, a byte that would
// be parsed waits in the input register and o_ready drops.
// Reset: parser returns to waiting for '*', arg_limit becomes 32, both
// registers empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bulk_string_array_parser_unit
    import bsap_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_kind,
    output logic [BYTE_W-1:0]      o_data_byte_res,
    output logic [IDX_W-1:0]       o_arg_index,
    output logic [CNT_W-1:0]       o_arg_count,
    output logic [LEN_W-1:0]       o_arg_length,
    output logic                   o_last_argument,
    output logic [2:0]             o_error_code,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_arg_limit
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [CNT_W-1:0]  r_arg_limit;
    logic              r_out_valid;
    t_result           r_out;

    logic              step;
    logic              res_valid;
    t_result           res;

    assign step        = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    bsap_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_arg_limit (r_arg_limit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_arg_limit <= C_ARG_RESET;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (step) begin
                r_out_valid <= res_valid;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_arg_limit <= i_arg_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_data_byte_res = r_out.data;
    assign o_arg_index     = r_out.idx;
    assign o_arg_count     = r_out.cnt;
    assign o_arg_length    = r_out.len;
    assign o_last_argument = r_out.last;
    assign o_error_code    = r_out.err;

endmodule

`default_nettype wire

// File: rtl/bsap_checker.sv
// ----------------------------------------------------------------------------
// bsap_checker
// Port-level checks of the parser's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsap_checker
    import bsap_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [1:0]        o_kind,
    input wire logic [BYTE_W-1:0] o_data_byte_res,
    input wire logic [IDX_W-1:0]  o_arg_index,
    input wire logic [CNT_W-1:0]  o_arg_count,
    input wire logic [LEN_W-1:0]  o_arg_length,
    input wire logic              o_last_argument,
    input wire logic [2:0]        o_error_code
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_data_byte_res)
            && $stable(o_arg_length) && $stable(o_error_code))
        else $error("result word changed while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == K_ERROR |-> o_data_byte_res == '0 && o_arg_index == '0
            && o_arg_count == '0 && o_arg_length == '0 && !o_last_argument)
        else $error("error word carries argument fields");

    a_no_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_PAYLOAD || o_kind == K_ARG_END) |-> o_error_code == '0)
        else $error("error code on non-error word");

    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_argument |-> o_kind == K_ARG_END
            && ({1'b0, o_arg_index} + CNT_W'(1)) >= o_arg_count)
        else $error("last flag outside final argument end");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_ERROR |-> {1'b0, o_arg_index} < o_arg_count)
        else $error("argument index beyond declared count");

endmodule

bind bulk_string_array_parser_unit bsap_checker u_bsap_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_kind          (o_kind),
    .o_data_byte_res (o_data_byte_res),
    .o_arg_index     (o_arg_index),
    .o_arg_count     (o_arg_count),
    .o_arg_length    (o_arg_length),
    .o_last_argument (o_last_argument),
    .o_error_code    (o_error_code)
);

`default_nettype wire

// File: bench/bulk_string_array_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// bulk_string_array_parser_unit_tb
// Self-checking bench for the byte-serial bulk string array parser.
//
// Request bytes go in one word per handshake. A behavioral parser inside the
// bench tracks every accepted byte and queues the result words the unit must
// return. A monitor compares each returned word, field by field, in order.
// The run covers count limits across arg_limit settings, number line forms,
// every error code, payload extremes, output back pressure, random well-formed
// and broken traffic, and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bulk_string_array_parser_unit_tb;
    import bsap_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 200;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [1:0]        o_kind;
    logic [BYTE_W-1:0] o_data_byte_res;
    logic [IDX_W-1:0]  o_arg_index;
    logic [CNT_W-1:0]  o_arg_count;
    logic [LEN_W-1:0]  o_arg_length;
    logic              o_last_argument;
    logic [2:0]        o_error_code;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_arg_limit = '0;

    bulk_string_array_parser_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_data_byte_res (o_data_byte_res),
        .o_arg_index     (o_arg_index),
        .o_arg_count     (o_arg_count),
        .o_arg_length    (o_arg_length),
        .o_last_argument (o_last_argument),
        .o_error_code    (o_error_code),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_arg_limit     (i_arg_limit)
    );

    // parser shadow state
    t_phase           ph;
    logic [NUM_W-1:0] num_val;
    t_nstage          num_stage;
    logic             num_neg;
    logic [LINE_W-1:0] line_cnt;
    logic [CNT_W-1:0] req_args;
    logic [IDX_W-1:0] cur_arg;
    logic [NUM_W-1:0] pay_left;
    logic [LEN_W-1:0] cur_len;
    logic [CNT_W-1:0] limit_reg;

    t_result expected_words[$];

    int    errors        = 0;
    int    bytes_sent    = 0;
    int    words_checked = 0;
    int    n_payload     = 0;
    int    n_arg_end     = 0;
    int    n_error       = 0;
    int    cfg_writes    = 0;
    bit    gaps_on       = 1'b1;
    bit    long_hold_req = 1'b0;
    string cr;
    string crlf;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        ph        = PH_STAR;
        num_val   = '0;
        num_stage = NS_SKIP;
        num_neg   = 1'b0;
        line_cnt  = '0;
        req_args  = '0;
        cur_arg   = '0;
        pay_left  = '0;
        cur_len   = '0;
    endfunction

    function automatic void begin_number();
        num_val   = '0;
        num_stage = NS_SKIP;
        num_neg   = 1'b0;
        line_cnt  = '0;
    endfunction

    function automatic void push_error(input t_err code);
        t_result r;
        clear_parser();
        r      = '0;
        r.kind = K_ERROR;
        r.err  = code;
        expected_words.push_back(r);
    endfunction

    function automatic int count_cap();
        return (int'(limit_reg) < ARG_CAP) ? int'(limit_reg) : ARG_CAP;
    endfunction

    function automatic void take_line_byte(input logic [7:0] c, input t_phase lf_phase);
        logic        is_digit;
        int unsigned v;
        if (c == C_CR) begin
            ph = lf_phase;
            return;
        end
        if (line_cnt >= C_LINE_MAX) begin
            push_error(E_LINE_LONG);
            return;
        end
        line_cnt++;
        is_digit = (c >= C_ZERO) && (c <= C_NINE);
        if (num_stage == NS_SKIP) begin
            if (c == C_SPACE || (c >= C_TAB && c <= C_FF))
                return;
            if (c == C_PLUS || c == C_MINUS) begin
                num_neg   = (c == C_MINUS);
                num_stage = NS_DIGITS;
                return;
            end
            num_stage = is_digit ? NS_DIGITS : NS_DONE;
        end else if (num_stage == NS_DIGITS && !is_digit) begin
            num_stage = NS_DONE;
        end
        if (num_stage == NS_DIGITS && is_digit) begin
            v       = num_val * 10 + (c - C_ZERO);
            num_val = (v > C_NUM_MAX) ? C_NUM_MAX : v[NUM_W-1:0];
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        t_result r;
        bit      last;
        r = '0;
        case (ph)
            PH_STAR: begin
                if (c != C_STAR) begin
                    push_error(E_NO_STAR);
                end else begin
                    begin_number();
                    ph = PH_COUNT;
                end
            end
            PH_COUNT: take_line_byte(c, PH_COUNT_LF);
            PH_COUNT_LF: begin
                if (c != C_LF) begin
                    push_error(E_CR_NO_LF);
                end else if (num_neg || num_val == 0 || int'(num_val) > count_cap()) begin
                    push_error(E_BAD_COUNT);
                end else begin
                    req_args = num_val[CNT_W-1:0];
                    cur_arg  = '0;
                    ph       = PH_DOLLAR;
                end
            end
            PH_DOLLAR: begin
                if (c != C_DOLLAR) begin
                    push_error(E_NO_DOLLAR);
                end else begin
                    begin_number();
                    ph = PH_LEN;
                end
            end
            PH_LEN: take_line_byte(c, PH_LEN_LF);
            PH_LEN_LF: begin
                if (c != C_LF) begin
                    push_error(E_CR_NO_LF);
                end else if (num_neg && num_val != 0) begin
                    push_error(E_NEG_LEN);
                end else if (num_val > C_LEN_MAX) begin
                    push_error(E_LEN_LARGE);
                end else begin
                    cur_len  = num_val[LEN_W-1:0];
                    pay_left = num_val;
                    ph       = (num_val == 0) ? PH_TRAIL1 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                r.kind = K_PAYLOAD;
                r.data = c;
                r.idx  = cur_arg;
                r.cnt  = req_args;
                r.len  = cur_len;
                expected_words.push_back(r);
                pay_left--;
                if (pay_left == 0)
                    ph = PH_TRAIL1;
            end
            PH_TRAIL1: ph = PH_TRAIL2;
            PH_TRAIL2: begin
                last   = (int'(cur_arg) + 1 >= int'(req_args));
                r.kind = K_ARG_END;
                r.idx  = cur_arg;
                r.cnt  = req_args;
                r.len  = cur_len;
                r.last = last;
                expected_words.push_back(r);
                if (last) begin
                    clear_parser();
                end else begin
                    cur_arg++;
                    ph = PH_DOLLAR;
                end
            end
            default: clear_parser();
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    // decimal text with random leading whitespace, sign, zeros and trailing junk
    function automatic string num_text(input int v);
        string s;
        string ws_chars;
        string junk;
        int    k;
        ws_chars = " \t\n\v\f";
        junk     = "x #.-+q";
        s = $sformatf("%0d", v);
        if (v >= 0) begin
            if ($urandom_range(0, 3) == 0)
                s = {"00", s};
            if ($urandom_range(0, 3) == 0)
                s = {"+", s};
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3))
                    s = {s, $sformatf("%c", junk[$urandom_range(0, junk.len() - 1)])};
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 3);
            repeat (k)
                s = {$sformatf("%c", ws_chars[$urandom_range(0, ws_chars.len() - 1)]), s};
        end
        return s;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_argument(input int len);
        send_text({"$", num_text(len), crlf});
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_request(input int nargs, input int max_len);
        send_text({"*", num_text(nargs), crlf});
        for (int a = 0; a < nargs; a++)
            send_argument($urandom_range(0, max_len));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_arg_limit(input logic [CNT_W-1:0] v);
        settle();
        i_cfg_valid <= 1'b1;
        i_arg_limit <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_reg = v;
        cfg_writes++;
    endtask

    task automatic send_broken();
        int cap;
        cap = count_cap();
        case ($urandom_range(0, 7))
            0: repeat ($urandom_range(1, 4)) send_byte(byte_other_than(C_STAR));
            1: begin
                case ($urandom_range(0, 4))
                    0: send_text({"*0", crlf});
                    1: send_text({"*", crlf});
                    2: send_text({"*", $sformatf("-%0d", $urandom_range(0, 9)), crlf});
                    3: send_text({"*", num_text(cap + $urandom_range(1, 40)), crlf});
                    default: send_text({"*99999", crlf});
                endcase
            end
            2: begin
                send_text({"*1", crlf});
                send_byte(byte_other_than(C_DOLLAR));
            end
            3: send_text({"*1", crlf, "$", $sformatf("-%0d", $urandom_range(1, 500)), crlf});
            4: send_text({"*1", crlf, "$", num_text($urandom_range(16384, 99999)), crlf});
            5: begin
                if ($urandom_range(0, 1) == 0)
                    send_text({"*", num_text($urandom_range(1, 3)), cr});
                else
                    send_text({"*1", crlf, "$", num_text($urandom_range(0, 5)), cr});
                send_byte(byte_other_than(C_LF));
            end
            6: begin
                if ($urandom_range(0, 1) == 0)
                    send_text("*");
                else
                    send_text({"*1", crlf, "$"});
                repeat (32) send_byte(byte_other_than(C_CR));
            end
            default: begin
                send_text({"*2", crlf});
                send_argument($urandom_range(0, 4));
                send_text("*");
            end
        endcase
    endtask

    task automatic random_traffic(input int n_bytes);
        int stop;
        int req_no;
        int cap;
        int nargs;
        stop   = bytes_sent + n_bytes;
        req_no = 0;
        while (bytes_sent < stop) begin
            if (req_no % 12 == 11) begin
                if ($urandom_range(0, 9) == 0)
                    write_arg_limit(6'($urandom_range(0, 63)));
                else
                    write_arg_limit(6'($urandom_range(1, 32)));
            end
            cap = count_cap();
            if (cap > 0 && $urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 7) == 0)
                    nargs = $urandom_range(1, cap);
                else
                    nargs = $urandom_range(1, (cap < 3) ? cap : 3);
                send_request(nargs, ($urandom_range(0, 9) == 0) ? 40 : 6);
            end else begin
                send_broken();
            end
            req_no++;
        end
    endtask

    task automatic test_count_limits();
        send_request(32, 1);
        send_text({"*33", crlf});
        write_arg_limit(6'd1);
        send_request(1, 2);
        send_text({"*2", crlf});
        write_arg_limit(6'd0);
        send_text({"*1", crlf});
        write_arg_limit(6'd63);
        send_request(32, 0);
        send_text({"*33", crlf});
        write_arg_limit(6'd32);
    endtask

    task automatic test_number_forms();
        send_text({"* \t\n\v\f+02x", crlf, "$-0", crlf, "ab", "$ 3abc", crlf});
        send_text({"xyz", "ab"});
        send_text({"*1", crlf, "$", crlf, "ab"});
        send_text({"*", crlf});
        send_text({"*99999", crlf});
        send_text({"*1", crlf, "$+-3", crlf, "ab"});
        send_text("*");
        repeat (30) send_byte(C_SPACE);
        send_text({"1", crlf, "$1", crlf, "Zab"});
        send_text({"*1", crlf, "$99999", crlf});
    endtask

    task automatic test_error_codes();
        send_text("x");
        send_text("*");
        repeat (32) send_byte("7");
        send_text({"*0", crlf});
        send_text({"*1", crlf, "#"});
        send_text({"*1", crlf, "$-7", crlf});
        send_text({"*1", crlf, "$16384", crlf});
        send_text({"*1", cr, "x"});
        send_text({"*1", crlf, "$2", cr, cr});
    endtask

    task automatic test_payload_extremes();
        send_text({"*2", crlf, "$256", crlf});
        for (int v = 0; v < 256; v++)
            send_byte(8'(v));
        send_text("ab");
        send_argument(0);
        send_text({"*1", crlf});
        send_argument(40);
    endtask

    task automatic test_backpressure();
        settle();
        long_hold_req = 1'b1;
        send_text({"*1", crlf});
        send_argument(60);
        settle();
    endtask

    task automatic test_random_traffic();
        random_traffic(150);
    endtask

    task automatic test_full_rate();
        settle();
        gaps_on = 1'b0;
        write_arg_limit(6'd32);
        random_traffic(80);
    endtask

    initial begin : result_monitor
        t_result want;
        int      stall_left;
        int      hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: kind %0d", o_kind);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("data_byte_res", want.data, o_data_byte_res);
                    check_field("arg_index", want.idx, o_arg_index);
                    check_field("arg_count", want.cnt, o_arg_count);
                    check_field("arg_length", want.len, o_arg_length);
                    check_field("last_argument", want.last, o_last_argument);
                    check_field("error_code", want.err, o_error_code);
                    words_checked++;
                    case (want.kind)
                        K_PAYLOAD: n_payload++;
                        K_ARG_END: n_arg_end++;
                        default:   n_error++;
                    endcase
                end
            end
            if (long_hold_req) begin
                hold_left     = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!gaps_on) begin
                stall_left = 0;
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_CYCLES) begin
                $display("timeout: no word moved for %0d cycles", WATCHDOG_CYCLES);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cr   = $sformatf("%c", C_CR);
        crlf = $sformatf("%c%c", C_CR, C_LF);
        clear_parser();
        limit_reg = C_ARG_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_count_limits();
        test_number_forms();
        test_error_codes();
        test_payload_extremes();
        test_backpressure();
        test_random_traffic();
        test_full_rate();

        settle();
        if (expected_words.size() != 0) begin
            $error("%0d expected result words never arrived", expected_words.size());
            errors++;
        end
        $display("Sent %0d request bytes over %0d arg_limit writes, incl. a long output stall.",
                 bytes_sent, cfg_writes);
        $display("Checked %0d words: %0d payload, %0d argument end, %0d parse error.",
                 words_checked, n_payload, n_arg_end, n_error);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/bsap_pkg.sv
rtl/bsap_num.sv
rtl/bsap_fsm.sv
rtl/bulk_string_array_parser_unit.sv
rtl/bsap_checker.sv
bench/bulk_string_array_parser_unit_tb.sv
